FILE: hw/rtl/cau_pkg.sv
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    // product width, signed sum width, quotient width, divider remainder width
    localparam int PW  = 2 * DATA_WIDTH;
    localparam int SW  = 2 * DATA_WIDTH + 2;
    localparam int QW  = DATA_WIDTH + 1;
    localparam int WW  = 2 * DATA_WIDTH + FRAC_BITS + QW;
    // one overflow check stage plus one stage per quotient bit
    localparam int NDS = QW + 1;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    // sign-magnitude item as it runs through the divider and into the output stage
    typedef struct packed {
        logic          is_div;
        logic          div0;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [PW-1:0] den;
        logic [WW-1:0] rem_re;
        logic [WW-1:0] rem_im;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
    } dv_t;

endpackage

FILE: hw/rtl/cau_front.sv
module cau_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_mode,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] s_first_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] s_first_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] s_second_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] s_second_imag,
    output logic                                  dv_valid,
    output cau_pkg::dv_t                          dv_data,
    input  logic                                  dv_ready
);
    import cau_pkg::*;

    logic rdy1, rdy2, rdy3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1: products
    mode_t                  mode1_reg;
    logic signed [DATA_WIDTH-1:0] a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [PW-1:0]   ac1_reg, bd1_reg, ad1_reg, bc1_reg, cc1_reg, dd1_reg;
    logic signed [PW-1:0]   ac_next, bd_next, ad_next, bc_next, cc_next, dd_next;
    logic                   zero1_reg;

    // stage 2: sums
    mode_t                  mode2_reg;
    logic                   zero2_reg;
    logic signed [SW-1:0]   re2_reg, im2_reg, re2_next, im2_next;
    logic [PW-1:0]          den2_reg;

    // stage 3: sign and magnitude
    dv_t                    dv3_reg, dv3_next;

    assign rdy3    = !v3_reg || dv_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign ac_next = PW'(s_first_real) * PW'(s_second_real);
    assign bd_next = PW'(s_first_imag) * PW'(s_second_imag);
    assign ad_next = PW'(s_first_real) * PW'(s_second_imag);
    assign bc_next = PW'(s_first_imag) * PW'(s_second_real);
    assign cc_next = PW'(s_second_real) * PW'(s_second_real);
    assign dd_next = PW'(s_second_imag) * PW'(s_second_imag);

    always_comb begin
        unique case (mode1_reg)
            MODE_ADD: begin
                re2_next = SW'(a1_reg) + SW'(c1_reg);
                im2_next = SW'(b1_reg) + SW'(d1_reg);
            end
            MODE_SUB: begin
                re2_next = SW'(a1_reg) - SW'(c1_reg);
                im2_next = SW'(b1_reg) - SW'(d1_reg);
            end
            MODE_MUL: begin
                re2_next = SW'(ac1_reg) - SW'(bd1_reg);
                im2_next = SW'(ad1_reg) + SW'(bc1_reg);
            end
            default: begin
                re2_next = SW'(ac1_reg) + SW'(bd1_reg);
                im2_next = SW'(bc1_reg) - SW'(ad1_reg);
            end
        endcase
    end

    always_comb begin
        logic [SW-1:0] mag_re, mag_im, m_re, m_im;
        mag_re = re2_reg[SW-1] ? SW'(-re2_reg) : SW'(re2_reg);
        mag_im = im2_reg[SW-1] ? SW'(-im2_reg) : SW'(im2_reg);
        m_re   = (mode2_reg == MODE_MUL) ? (mag_re >> FRAC_BITS) : mag_re;
        m_im   = (mode2_reg == MODE_MUL) ? (mag_im >> FRAC_BITS) : mag_im;
        dv3_next.is_div = (mode2_reg == MODE_DIV);
        dv3_next.div0   = (mode2_reg == MODE_DIV) && zero2_reg;
        dv3_next.neg_re = re2_reg[SW-1];
        dv3_next.neg_im = im2_reg[SW-1];
        dv3_next.den    = den2_reg;
        dv3_next.rem_re = WW'(mag_re) << FRAC_BITS;
        dv3_next.rem_im = WW'(mag_im) << FRAC_BITS;
        if (mode2_reg == MODE_DIV) begin
            dv3_next.ovf_re = 1'b0;
            dv3_next.ovf_im = 1'b0;
            dv3_next.q_re   = '0;
            dv3_next.q_im   = '0;
        end else begin
            dv3_next.ovf_re = |m_re[SW-1:QW];
            dv3_next.ovf_im = |m_im[SW-1:QW];
            dv3_next.q_re   = m_re[QW-1:0];
            dv3_next.q_im   = m_im[QW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            mode1_reg <= mode_t'(s_mode);
            a1_reg    <= s_first_real;
            b1_reg    <= s_first_imag;
            c1_reg    <= s_second_real;
            d1_reg    <= s_second_imag;
            ac1_reg   <= ac_next;
            bd1_reg   <= bd_next;
            ad1_reg   <= ad_next;
            bc1_reg   <= bc_next;
            cc1_reg   <= cc_next;
            dd1_reg   <= dd_next;
            zero1_reg <= (s_second_real == '0) && (s_second_imag == '0);
        end
        if (rdy2 && v1_reg) begin
            mode2_reg <= mode1_reg;
            zero2_reg <= zero1_reg;
            re2_reg   <= re2_next;
            im2_reg   <= im2_next;
            den2_reg  <= PW'($unsigned(cc1_reg)) + PW'($unsigned(dd1_reg));
        end
        if (rdy3 && v2_reg) begin
            dv3_reg <= dv3_next;
        end
    end

    assign dv_valid = v3_reg;
    assign dv_data  = dv3_reg;

endmodule

FILE: hw/rtl/cau_divider.sv
module cau_divider (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         up_valid,
    input  cau_pkg::dv_t up_data,
    output logic         up_ready,
    output logic         dn_valid,
    output cau_pkg::dv_t dn_data,
    input  logic         dn_ready
);
    import cau_pkg::*;

    dv_t            st_reg [NDS];
    logic [NDS-1:0] v_reg;
    logic [NDS:0]   rdy;

    assign rdy[NDS]  = dn_ready;
    assign up_ready  = rdy[0];
    assign dn_valid  = v_reg[NDS-1];
    assign dn_data   = st_reg[NDS-1];

    for (genvar j = 0; j < NDS; j++) begin : g_st
        dv_t  in_d;
        logic in_v;
        dv_t  st_next;

        if (j == 0) begin : g_first
            assign in_d = up_data;
            assign in_v = up_valid;
            // quotient would not fit in QW bits
            always_comb begin
                st_next = in_d;
                if (in_d.is_div && !in_d.div0) begin
                    st_next.ovf_re = (in_d.rem_re >= (WW'(in_d.den) << QW));
                    st_next.ovf_im = (in_d.rem_im >= (WW'(in_d.den) << QW));
                end
            end
        end else begin : g_bit
            localparam int K = QW - j;
            logic [WW-1:0] sh;
            assign in_d = st_reg[j-1];
            assign in_v = v_reg[j-1];
            assign sh   = WW'(in_d.den) << K;
            always_comb begin
                st_next = in_d;
                if (in_d.is_div && !in_d.div0) begin
                    if (!in_d.ovf_re && (in_d.rem_re >= sh)) begin
                        st_next.rem_re = in_d.rem_re - sh;
                        st_next.q_re[K] = 1'b1;
                    end
                    if (!in_d.ovf_im && (in_d.rem_im >= sh)) begin
                        st_next.rem_im = in_d.rem_im - sh;
                        st_next.q_im[K] = 1'b1;
                    end
                end
            end
        end

        assign rdy[j] = !v_reg[j] || rdy[j+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                v_reg[j] <= in_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j] && in_v) begin
                st_reg[j] <= st_next;
            end
        end
    end

endmodule

FILE: hw/rtl/cau_out.sv
module cau_out (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  up_valid,
    input  cau_pkg::dv_t                          up_data,
    output logic                                  up_ready,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] m_result_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] m_result_imag,
    output logic [1:0]                            m_status
);
    import cau_pkg::*;

    localparam logic [QW-1:0] LIM_POS = (QW'(1) << (DATA_WIDTH - 1)) - QW'(1);
    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (DATA_WIDTH - 1);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] re_reg, im_reg, re_next, im_next;
    status_t               status_reg, status_next;

    assign up_ready = !valid_reg || m_ready;

    always_comb begin
        logic [QW-1:0] lim_re, lim_im, mag_re, mag_im, val_re, val_im;
        logic          sat_re, sat_im;
        lim_re = up_data.neg_re ? LIM_NEG : LIM_POS;
        lim_im = up_data.neg_im ? LIM_NEG : LIM_POS;
        sat_re = up_data.ovf_re || (up_data.q_re > lim_re);
        sat_im = up_data.ovf_im || (up_data.q_im > lim_im);
        mag_re = sat_re ? lim_re : up_data.q_re;
        mag_im = sat_im ? lim_im : up_data.q_im;
        val_re = up_data.neg_re ? QW'(-mag_re) : mag_re;
        val_im = up_data.neg_im ? QW'(-mag_im) : mag_im;
        if (up_data.div0) begin
            re_next     = '0;
            im_next     = '0;
            status_next = ST_DIV0;
        end else begin
            re_next     = val_re[DATA_WIDTH-1:0];
            im_next     = val_im[DATA_WIDTH-1:0];
            status_next = (sat_re || sat_im) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            re_reg     <= re_next;
            im_reg     <= im_next;
            status_reg <= status_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_result_real = $signed(re_reg);
    assign m_result_imag = $signed(im_reg);
    assign m_status      = status_reg;

endmodule

FILE: hw/rtl/complex_arithmetic_unit_top.sv
// Complex ALU on signed Q8.8 operands: add, subtract, multiply and divide, with saturation
// and a divide-by-zero status. Fully pipelined: one transfer can be accepted every cycle
// unless back-pressure from the result side has filled the pipeline. Every operation passes
// through the same stages, so results leave in the order they came. The divider resolves
// one quotient bit per pipeline stage after an overflow check stage. Stalls on the result
// side collapse bubbles first and lose nothing.
module complex_arithmetic_unit_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_mode,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] s_first_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] s_first_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] s_second_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] s_second_imag,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] m_result_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] m_result_imag,
    output logic [1:0]                            m_status
);
    import cau_pkg::*;

    logic fr_valid, fr_ready, dv_valid, dv_ready;
    dv_t  fr_data, dv_data;

    cau_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_first_real  (s_first_real),
        .s_first_imag  (s_first_imag),
        .s_second_real (s_second_real),
        .s_second_imag (s_second_imag),
        .dv_valid      (fr_valid),
        .dv_data       (fr_data),
        .dv_ready      (fr_ready)
    );

    cau_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (fr_valid),
        .up_data  (fr_data),
        .up_ready (fr_ready),
        .dn_valid (dv_valid),
        .dn_data  (dv_data),
        .dn_ready (dv_ready)
    );

    cau_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .up_valid      (dv_valid),
        .up_data       (dv_data),
        .up_ready      (dv_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_real (m_result_real),
        .m_result_imag (m_result_imag),
        .m_status      (m_status)
    );

endmodule

FILE: verif/cau_checker.sv
`timescale 1ns / 1ps

module cau_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_first_real,
    input  logic [15:0] s_first_imag,
    input  logic [15:0] s_second_real,
    input  logic [15:0] s_second_imag,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_result_real,
    input  logic [15:0] m_result_imag,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending,
    output int          n_results
);
    import cau_pkg::*;

    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic [1:0]  st;
    } cplx_res_t;

    cplx_res_t expected_q[$];

    // clamp a wide signed value to 16 bits, flagging saturation
    function automatic logic [15:0] clamp16(input longint v, inout bit sat);
        if (v > 32767) begin
            sat = 1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            sat = 1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // magnitude-based truncation toward zero
    function automatic longint trunc_div(input longint num, input longint den);
        longint m;
        m = (num < 0) ? -num : num;
        m = m / den;
        return (num < 0) ? -m : m;
    endfunction

    function automatic cplx_res_t predict_complex(input logic [1:0] md,
            input logic [15:0] ar, input logic [15:0] ai,
            input logic [15:0] br, input logic [15:0] bi);
        longint a, b, c, d, re, im, den;
        cplx_res_t r;
        bit sat;
        a = longint'($signed(ar));
        b = longint'($signed(ai));
        c = longint'($signed(br));
        d = longint'($signed(bi));
        sat = 0;
        case (md)
            MODE_ADD: begin
                re = a + c;
                im = b + d;
            end
            MODE_SUB: begin
                re = a - c;
                im = b - d;
            end
            MODE_MUL: begin
                re = trunc_div(a * c - b * d, 256);
                im = trunc_div(a * d + b * c, 256);
            end
            default: begin
                if (c == 0 && d == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = ST_DIV0;
                    return r;
                end
                den = c * c + d * d;
                re = trunc_div((a * c + b * d) * 256, den);
                im = trunc_div((b * c - a * d) * 256, den);
            end
        endcase
        r.re = clamp16(re, sat);
        r.im = clamp16(im, sat);
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        cplx_res_t e;
        int        nf;
        nf = 0;
        if (!aresetn) begin
            fail_count <= 0;
            n_results  <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(predict_complex(s_mode, s_first_real, s_first_imag,
                                                     s_second_real, s_second_imag));
            if (m_valid && m_ready) begin
                n_results <= n_results + 1;
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    nf++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_result_real !== e.re) begin
                        $error("result_real expected %h actual %h", e.re, m_result_real);
                        nf++;
                    end
                    if (m_result_imag !== e.im) begin
                        $error("result_imag expected %h actual %h", e.im, m_result_imag);
                        nf++;
                    end
                    if (m_status !== e.st) begin
                        $error("status expected %0d actual %0d", e.st, m_status);
                        nf++;
                    end
                end
            end
            fail_count <= fail_count + nf;
        end
    end
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import cau_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_RANDOM = 620;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_mode = MODE_ADD;
    logic [15:0] s_first_real = 0;
    logic [15:0] s_first_imag = 0;
    logic [15:0] s_second_real = 0;
    logic [15:0] s_second_imag = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_result_real;
    logic [15:0] m_result_imag;
    logic [1:0]  m_status;
    int          fail_count;
    int          pending;
    int          n_results;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 0;
    int          idle_cycles = 0;
    int          n_sent = 0;

    always #5 aclk = ~aclk;

    complex_arithmetic_unit_top u_dut (.*);

    cau_checker u_chk (.*);

    // receiver side
    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] rand_part();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // valid stays high between back-to-back transfers, drops only while idling
    task automatic send_op(input logic [1:0] md, input logic [15:0] ar,
                           input logic [15:0] ai, input logic [15:0] br,
                           input logic [15:0] bi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid       <= 1;
        s_mode        <= md;
        s_first_real  <= ar;
        s_first_imag  <= ai;
        s_second_real <= br;
        s_second_imag <= bi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
        @(negedge aclk);
    endtask

    initial begin
        logic [15:0] ext[4];
        ext = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: extremes, every op, divide by zero
        for (int m = 0; m < 4; m++) begin
            send_op(m[1:0], ext[m], ext[(m + 1) % 4], ext[(m + 2) % 4], ext[(m + 3) % 4]);
            send_op(m[1:0], 16'h0100, 16'h0200, 16'h0300, 16'hff00);
            send_op(m[1:0], 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
            send_op(m[1:0], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        end
        send_op(MODE_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
        send_op(MODE_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
        send_op(MODE_DIV, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
        send_op(MODE_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
        // long receiver hold-off while the sender keeps going
        hold_off = 1;
        fork
            begin
                repeat (200) @(negedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 60; i++)
                send_op(2'($urandom), rand_part(), rand_part(), rand_part(), rand_part());
        join
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = (p == 1) ? 45 : (p == 3) ? 29 : 0;
            recv_stall_pct = (p == 2) ? 45 : (p == 3) ? 29 : 0;
            for (int i = 0; i < N_RANDOM / 4; i++)
                send_op(2'($urandom), rand_part(), rand_part(), rand_part(), rand_part());
        end
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("sent %0d operand pairs over all four ops, %0d results checked", n_sent,
                 n_results);
        $display("covered idle and stall phases and a long output hold-off");
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
